// ----- rtl/sau_pkg.sv -----
// Shared constants for the stack arithmetic unit.
`timescale 1ns / 1ps
package sau_pkg;

   localparam int DATA_W        = 32;
   localparam int LINE_W        = 16;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 7;
   localparam int DEFAULT_DEPTH = 64;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   localparam logic [KIND_W-1:0] KIND_NOP  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SWAP = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ADD  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SUB  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DIV  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// ----- rtl/stack_arithmetic_unit_top.sv -----
// Stack arithmetic unit: bounded operand stack with push, add, sub, swap and divide.
//
// req channel: one opcode per transfer; tuser carries the kind, tdata the push
// value and the source line. rsp channel: exactly one result per opcode with
// the status in tuser and the new top, entry count and echoed line in tdata.
// Entries below the top live in a simple dual-port synchronous RAM; the top
// entry sits in a register, so each opcode needs one RAM read and at most one write.
// Nop, push, swap, add, sub and every error go from the request transfer to a
// valid result through the accept, execute and commit steps. A valid divide
// also passes through the bit-serial restoring divider, one quotient bit per
// cycle. One opcode is in flight at a time; req_tready is high whenever the
// sequencer is idle, also while an earlier result still waits. While that
// result is not taken, the finished opcode holds in its commit step and the
// stack is not updated until it is.
// Reset empties the stack and drops any pending result; RAM contents stay as
// they are and are only read after being written.
`timescale 1ns / 1ps
module stack_arithmetic_unit_top #(
   parameter int STACK_DEPTH = sau_pkg::DEFAULT_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] push_value, [47:32] line_number
   input  logic [sau_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] kind
   input  logic [sau_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] top_value, [38:32] stack_count, [54:39] error_line, [55] zero
   output logic [sau_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [sau_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int DW  = sau_pkg::DATA_W;
   localparam int LW  = sau_pkg::LINE_W;
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int DCW = $clog2(DW);
   localparam logic [CW-1:0]  COUNT_FULL = CW'(STACK_DEPTH);
   localparam logic [DCW-1:0] DIV_LAST   = DCW'(DW - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [DW-1:0] stack_mem [STACK_DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_wr;

   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] top_ff, top_in;

   logic [sau_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [DW-1:0]              pv_ff, pv_in;
   logic [LW-1:0]              line_ff, line_in;

   logic [sau_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CW-1:0]                res_count_ff, res_count_in;
   logic [DW-1:0]                res_top_ff, res_top_in;
   logic                         res_wr_ff, res_wr_in;
   logic [AW-1:0]                res_addr_ff, res_addr_in;

   logic [DW-1:0]  quot_ff, quot_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  den_ff, den_in;
   logic           neg_ff, neg_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [DW:0]    trial;
   logic [DW-1:0]  quot_step;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sau_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DW-1:0]                rsp_top_ff, rsp_top_in;
   logic [sau_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [LW-1:0]                rsp_line_ff, rsp_line_in;

   logic out_free;
   logic req_xfer;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] count_m2;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_xfer = req_tvalid && req_tready;
   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign rd_addr  = count_m2[AW-1:0];
   assign mem_wr   = (state_ff == S_FIN) && out_free && res_wr_ff;

   assign trial     = {rem_ff, quot_ff[DW-1]} - {1'b0, den_ff};
   assign quot_step = {quot_ff[DW-2:0], !trial[DW]};

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         stack_mem[res_addr_ff] <= top_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      kind_in       = kind_ff;
      pv_in         = pv_ff;
      line_in       = line_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_top_in    = res_top_ff;
      res_wr_in     = res_wr_ff;
      res_addr_in   = res_addr_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_line_in   = rsp_line_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_tuser;
               pv_in    = req_tdata[DW-1:0];
               line_in  = req_tdata[DW+LW-1:DW];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = sau_pkg::ST_OK;
            res_count_in  = count_ff;
            res_top_in    = top_ff;
            res_wr_in     = 1'b0;
            res_addr_in   = count_m1[AW-1:0];
            state_in      = S_FIN;
            unique case (kind_ff)
               sau_pkg::KIND_PUSH: begin
                  if (count_ff == COUNT_FULL) begin
                     res_status_in = sau_pkg::ST_FULL;
                  end else begin
                     res_count_in = count_ff + CW'(1);
                     res_top_in   = pv_ff;
                     res_wr_in    = (count_ff != '0);
                  end
               end
               sau_pkg::KIND_SWAP, sau_pkg::KIND_ADD,
               sau_pkg::KIND_SUB, sau_pkg::KIND_DIV: begin
                  if (count_ff < CW'(2)) begin
                     res_status_in = sau_pkg::ST_TOO_SHORT;
                  end else if (kind_ff == sau_pkg::KIND_SWAP) begin
                     res_top_in  = rd_data_ff;
                     res_wr_in   = 1'b1;
                     res_addr_in = count_m2[AW-1:0];
                  end else if (kind_ff == sau_pkg::KIND_ADD) begin
                     res_top_in   = rd_data_ff + top_ff;
                     res_count_in = count_m1;
                  end else if (kind_ff == sau_pkg::KIND_SUB) begin
                     res_top_in   = rd_data_ff - top_ff;
                     res_count_in = count_m1;
                  end else if (top_ff == '0) begin
                     res_status_in = sau_pkg::ST_DIV_ZERO;
                  end else begin
                     res_count_in = count_m1;
                     quot_in      = rd_data_ff[DW-1] ? -rd_data_ff : rd_data_ff;
                     den_in       = top_ff[DW-1] ? -top_ff : top_ff;
                     rem_in       = '0;
                     neg_in       = rd_data_ff[DW-1] ^ top_ff[DW-1];
                     div_cnt_in   = '0;
                     state_in     = S_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            quot_in    = quot_step;
            rem_in     = trial[DW] ? {rem_ff[DW-2:0], quot_ff[DW-1]} : trial[DW-1:0];
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DIV_LAST) begin
               res_top_in = neg_ff ? -quot_step : quot_step;
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               count_in      = res_count_ff;
               top_in        = res_top_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_top_in    = (res_count_ff == '0) ? '0 : res_top_ff;
               rsp_count_in  = sau_pkg::COUNT_OUT_W'(res_count_ff);
               rsp_line_in   = line_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      kind_ff       <= kind_in;
      pv_ff         <= pv_in;
      line_ff       <= line_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_top_ff    <= res_top_in;
      res_wr_ff     <= res_wr_in;
      res_addr_ff   <= res_addr_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_line_ff   <= rsp_line_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_line_ff, rsp_count_ff, rsp_top_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("entry count beyond stack depth");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> den_ff != '0)
      else $error("divider running with zero divisor");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sau_pkg::ST_FULL |-> count_ff == COUNT_FULL)
      else $error("full status with stack not full");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_FIN))
      else $error("result raised outside commit step");
`endif

endmodule
